[sv/stack_heap_allocator_assert.svh]
// Assertion macros for the stack heap allocator checker.
`ifndef STACK_HEAP_ALLOCATOR_ASSERT_SVH
`define STACK_HEAP_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack_heap_allocator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack_heap_allocator: next-cycle check failed");

`endif

[sv/sha_pkg.sv]
// Types, codes and constants for the stack heap allocator.
package sha_pkg;

    localparam int MAX_BLOCKS_DEF = 64;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 32;
    localparam int HDR_W     = 8;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOMEM    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE = 2'd2;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RST   = 32'd0;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST  = 32'd65536;
    localparam logic [HDR_W-1:0]  HEADER_SIZE_RST = 8'd32;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] req_size;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_addr;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   copy_src;
        logic [SIZE_W-1:0]   copy_len;
    } t_rsp;

    // One datapath operation per cycle, issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RES_ADDR,
        OP_NOTFOUND,
        OP_SRCH_INIT,
        OP_SRCH_RD,
        OP_SRCH_NEXT,
        OP_MARK,
        OP_POP_BASE,
        OP_POP_RD,
        OP_POP_DEC,
        OP_POP_BRK,
        OP_ALLOC_CALC,
        OP_ALLOC_COMMIT,
        OP_ALLOC_FAIL,
        OP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             addr_zero;
        logic             size_zero;
        logic             count_zero;
        logic             idx_zero;
        logic             match;
        logic             fits;
        logic             rd_used;
        logic             alloc_ok;
        logic             out_free;
    } t_dp_sts;

endpackage

[sv/stack_heap_allocator.sv]
// Stack heap allocator top level: bump-pointer allocation over a stack of
// block records. One command is worked on at a time; the next is taken as soon
// as the result sits in the output register, even while that beat is still
// stalled. Allocate passes through decode, allocation and result. Free and
// reallocate may search the records top-down by address and pop released
// blocks off the top of the stack, with a final pop check when the stack
// empties. The record memory is read one record per access with a registered
// read. No clearing pass is needed after reset. Configuration is to be written
// by the user only while the block is idle; the block itself does not enforce
// this.
module stack_heap_allocator #(
    parameter int MAX_BLOCKS = sha_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sha_pkg::t_req                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sha_pkg::t_rsp                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [sha_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sha_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import sha_pkg::*;

    t_dp_op  op;
    t_dp_sts sts;

    sha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_op       (op)
    );

    sha_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[sv/sha_ctrl.sv]
// Sequencing state machine for the stack heap allocator.
module sha_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sha_pkg::t_dp_sts i_sts,
    output sha_pkg::t_dp_op  o_op
);
    import sha_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_SRD    = 9'b000000100,
        S_SCMP   = 9'b000001000,
        S_PRD    = 9'b000010000,
        S_PCMP   = 9'b000100000,
        S_ACALC  = 9'b001000000,
        S_ACHK   = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   is_free;

    assign is_free    = (i_sts.cmd == CMD_FREE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.cmd)
                    CMD_ALLOC: n_state = S_ACALC;
                    CMD_FREE: begin
                        if (i_sts.addr_zero) begin
                            n_state = S_DONE;
                        end else if (i_sts.count_zero) begin
                            o_op    = OP_NOTFOUND;
                            n_state = S_PRD;
                        end else begin
                            o_op    = OP_SRCH_INIT;
                            n_state = S_SRD;
                        end
                    end
                    CMD_REALLOC: begin
                        if (i_sts.addr_zero) begin
                            n_state = S_ACALC;
                        end else if (i_sts.size_zero) begin
                            o_op    = OP_RES_ADDR;
                            n_state = S_DONE;
                        end else if (i_sts.count_zero) begin
                            o_op    = OP_NOTFOUND;
                            n_state = S_DONE;
                        end else begin
                            o_op    = OP_SRCH_INIT;
                            n_state = S_SRD;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SRD: begin
                o_op    = OP_SRCH_RD;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (i_sts.match) begin
                    if (!is_free && i_sts.fits) begin
                        o_op    = OP_RES_ADDR;
                        n_state = S_DONE;
                    end else begin
                        o_op    = OP_MARK;
                        n_state = S_PRD;
                    end
                end else if (i_sts.idx_zero) begin
                    o_op    = OP_NOTFOUND;
                    n_state = is_free ? S_PRD : S_DONE;
                end else begin
                    o_op    = OP_SRCH_NEXT;
                    n_state = S_SRD;
                end
            end
            S_PRD: begin
                if (i_sts.count_zero) begin
                    o_op    = OP_POP_BASE;
                    n_state = is_free ? S_DONE : S_ACALC;
                end else begin
                    o_op    = OP_POP_RD;
                    n_state = S_PCMP;
                end
            end
            S_PCMP: begin
                if (i_sts.rd_used) begin
                    o_op    = OP_POP_BRK;
                    n_state = is_free ? S_DONE : S_ACALC;
                end else begin
                    o_op    = OP_POP_DEC;
                    n_state = S_PRD;
                end
            end
            S_ACALC: begin
                o_op    = OP_ALLOC_CALC;
                n_state = S_ACHK;
            end
            S_ACHK: begin
                o_op    = i_sts.alloc_ok ? OP_ALLOC_COMMIT : OP_ALLOC_FAIL;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_op    = OP_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/sha_dp.sv]
// Datapath of the stack heap allocator: registers, record memory, arithmetic.
module sha_dp #(
    parameter int MAX_BLOCKS = sha_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sha_pkg::t_dp_op                 i_op,
    output sha_pkg::t_dp_sts                o_sts,
    input  sha_pkg::t_req                   i_in_data,
    input  logic                            i_cfg_we,
    input  logic [sha_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sha_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output sha_pkg::t_rsp                   o_out_data
);
    import sha_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] start;
    } t_row;

    // configuration
    logic [ADDR_W-1:0] r_heap_base;
    logic [ADDR_W-1:0] r_heap_limit;
    logic [HDR_W-1:0]  r_header_size;

    // allocator state
    logic [ADDR_W-1:0] r_brk;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_idx;

    // current item and working values
    logic [CMD_W-1:0]  r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W:0]   r_data;
    logic [CNT_W-1:0]  r_sv_count;
    logic [ADDR_W-1:0] r_sv_brk;
    logic              r_sv_used;
    logic [SIZE_W-1:0] r_old_size;
    t_rsp              r_rsp;

    // output stage
    logic              r_out_valid;
    t_rsp              r_out;

    // record memory
    t_row              r_mem [MAX_BLOCKS];
    t_row              r_rdata;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_row              wr_row;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    logic [CNT_W-1:0]  count_m1;
    logic [IDX_W-1:0]  top_idx;
    logic [ADDR_W+1:0] alloc_end;
    logic [ADDR_W:0]   pop_end;
    logic              nomem;
    logic              full;
    logic              moving;

    assign count_m1  = r_count - CNT_W'(1);
    assign top_idx   = count_m1[IDX_W-1:0];
    assign alloc_end = {1'b0, r_data} + (ADDR_W + 2)'(r_size);
    assign pop_end   = {1'b0, r_rdata.start} + (ADDR_W + 1)'(r_rdata.size);
    assign nomem     = (alloc_end > (ADDR_W + 2)'(r_heap_limit));
    assign full      = (r_count == CNT_W'(MAX_BLOCKS));
    // a reallocate that reaches the allocation step with a live address is a move
    assign moving    = (r_cmd == CMD_REALLOC) && (r_addr != '0);

    assign o_sts.cmd        = r_cmd;
    assign o_sts.addr_zero  = (r_addr == '0);
    assign o_sts.size_zero  = (r_size == '0);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.match      = (r_rdata.start == r_addr);
    assign o_sts.fits       = (r_rdata.size >= r_size);
    assign o_sts.rd_used    = r_rdata.used;
    assign o_sts.alloc_ok   = (r_size != '0) && !full && !nomem;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_row  = '{used: 1'b0, size: r_rdata.size, start: r_rdata.start};
        rd_en   = 1'b0;
        rd_addr = r_idx;
        case (i_op)
            OP_MARK: wr_en = 1'b1;
            OP_ALLOC_COMMIT: begin
                wr_en   = 1'b1;
                wr_addr = r_count[IDX_W-1:0];
                wr_row  = '{used: 1'b1, size: r_size, start: r_data[ADDR_W-1:0]};
            end
            OP_ALLOC_FAIL: begin
                // put the moved-from record back as it was
                wr_en  = moving;
                wr_row = '{used: r_sv_used, size: r_old_size, start: r_addr};
            end
            OP_SRCH_RD: rd_en = 1'b1;
            OP_POP_RD: begin
                rd_en   = 1'b1;
                rd_addr = top_idx;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base   <= HEAP_BASE_RST;
            r_heap_limit  <= HEAP_LIMIT_RST;
            r_header_size <= HEADER_SIZE_RST;
            r_brk         <= HEAP_BASE_RST;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEAP_BASE: begin
                        r_heap_base <= i_cfg_wdata[ADDR_W-1:0];
                        if (r_count == '0) begin
                            r_brk <= i_cfg_wdata[ADDR_W-1:0];
                        end
                    end
                    CFG_HEAP_LIMIT:  r_heap_limit  <= i_cfg_wdata[ADDR_W-1:0];
                    CFG_HEADER_SIZE: r_header_size <= i_cfg_wdata[HDR_W-1:0];
                    default: ;
                endcase
            end
            case (i_op)
                OP_POP_BASE: r_brk <= r_heap_base;
                OP_POP_DEC:  r_count <= count_m1;
                OP_POP_BRK:  r_brk <= pop_end[ADDR_W-1:0];
                OP_ALLOC_COMMIT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_brk   <= alloc_end[ADDR_W-1:0];
                end
                OP_ALLOC_FAIL: begin
                    if (moving) begin
                        r_count <= r_sv_count;
                        r_brk   <= r_sv_brk;
                    end
                end
                default: ;
            endcase
            if (i_op == OP_OUT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_cmd  <= i_in_data.cmd;
                r_addr <= i_in_data.addr;
                r_size <= i_in_data.req_size;
                r_rsp  <= '0;
            end
            OP_RES_ADDR:  r_rsp.result_addr <= r_addr;
            OP_NOTFOUND:  r_rsp.status <= ST_NOTFOUND;
            OP_SRCH_INIT: r_idx <= top_idx;
            OP_SRCH_NEXT: r_idx <= r_idx - IDX_W'(1);
            OP_MARK: begin
                r_sv_count <= r_count;
                r_sv_brk   <= r_brk;
                r_sv_used  <= r_rdata.used;
                r_old_size <= r_rdata.size;
            end
            OP_ALLOC_CALC: r_data <= {1'b0, r_brk} + (ADDR_W + 1)'(r_header_size);
            OP_ALLOC_COMMIT: begin
                r_rsp.result_addr <= r_data[ADDR_W-1:0];
                if (moving) begin
                    // old block was smaller than the request, so copy all of it
                    r_rsp.copy_src <= r_addr;
                    r_rsp.copy_len <= r_old_size;
                end
            end
            OP_ALLOC_FAIL: begin
                if (r_size == '0) begin
                    r_rsp.status <= ST_ZERO;
                end else if (full) begin
                    r_rsp.status <= ST_FULL;
                end else begin
                    r_rsp.status <= ST_NOMEM;
                end
            end
            OP_OUT_LOAD: r_out <= r_rsp;
            default: ;
        endcase
    end

endmodule

[sv/sha_chk.sv]
// Port-level checker for the stack heap allocator, bound to the top level.
`include "stack_heap_allocator_assert.svh"

module sha_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_stall,
    input logic          i_out_valid,
    input logic          i_out_stall,
    input sha_pkg::t_rsp i_out_data
);
    import sha_pkg::*;

    // one command at a time: busy straight after a beat is taken
    `SHA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)

    `SHA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data))

    // copy fields only come with a successful move
    `SHA_ASSERT_SAME(a_copy_only_ok, i_clk, i_rst_n, i_out_valid && (i_out_data.status != ST_OK), (i_out_data.copy_src == '0) && (i_out_data.copy_len == '0))

    // every error returns null
    `SHA_ASSERT_SAME(a_error_null, i_clk, i_rst_n, i_out_valid && ((i_out_data.status == ST_ZERO) || (i_out_data.status == ST_NOMEM) || (i_out_data.status == ST_FULL) || (i_out_data.status == ST_NOTFOUND)), i_out_data.result_addr == '0)

endmodule

bind stack_heap_allocator sha_chk u_sha_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
